/* rtl/core/femt_pkg.sv */
// Package for the fault event memory table: operation codes, command and
// status structures shared by the controller and the datapath. No dependencies.
package femt_pkg;

    typedef enum logic [2:0] {
        OP_STORE   = 3'd0,
        OP_CLR_ONE = 3'd1,
        OP_CLR_ALL = 3'd2,
        OP_AGE     = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    localparam logic [7:0] SAT_MAX = 8'hFF;
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic start;
        logic scan;
        logic fetch;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } stat_t;

endpackage

/* rtl/core/femt_ctrl.sv */
// Controller of the fault event memory table: sequences accept, slot scan,
// target fetch and execute. Depends on femt_pkg.
module femt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  femt_pkg::stat_t stat,
    output femt_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_EXEC  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                // Hold here until the previous result has left the output register.
                if (stat.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/femt_dp.sv */
// Datapath of the fault event memory table: slot tables, scan trackers,
// operation execute logic and the result register. Depends on femt_pkg.
module femt_dp #(
    parameter int ENTRIES = 8,
    parameter int EVENTS  = 255
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  femt_pkg::cmd_t  cmd,
    output femt_pkg::stat_t stat,
    input  logic [2:0]      in_op,
    input  logic [72:0]     in_data,
    input  logic            cfg_disabled,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [55:0]     m_tdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // Latched transaction.
    logic [2:0]  op_reg;
    logic [7:0]  ev_reg, prio_reg, lim_reg, st_reg, cc_reg;
    logic        sok_reg;
    logic [31:0] ts_reg;

    // Event number per slot; zero marks a free slot.
    logic [7:0] slot_event_reg [ENTRIES];

    // Entry payload stores.
    logic [7:0]  mem_prio [ENTRIES];
    logic [7:0]  mem_lim  [ENTRIES];
    logic [7:0]  mem_occ  [ENTRIES];
    logic [7:0]  mem_age  [ENTRIES];
    logic [7:0]  mem_conf [ENTRIES];
    logic [7:0]  mem_stat [ENTRIES];
    logic [31:0] mem_time [ENTRIES];
    logic [7:0]  rd_prio_reg, rd_lim_reg, rd_occ_reg, rd_age_reg, rd_conf_reg, rd_stat_reg;
    logic [31:0] rd_time_reg;

    // Scan trackers.
    logic [CW-1:0] cnt_reg, used_reg;
    logic          pv_reg;
    logic [IW-1:0] pidx_reg;
    logic          hit_reg, free_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg, cand_reg;
    logic [7:0]    worst_reg;
    logic [31:0]   oldest_reg;

    logic          ev_valid;
    logic [IW-1:0] target, rd_addr;
    logic [7:0]    pev;

    assign ev_valid = (ev_reg != 8'd0) && (ev_reg <= 8'(EVENTS));
    assign target   = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : cand_reg);
    // Outside the scan the read port stays on the target, so a stalled execute
    // step still sees the fetched entry.
    assign rd_addr  = cmd.scan ? cnt_reg[IW-1:0] : target;
    assign pev      = slot_event_reg[pidx_reg];

    assign stat.scan_done = (cnt_reg == CW'(ENTRIES)) && !pv_reg;
    assign stat.out_free  = !m_tvalid || m_tready;

    // Execute-phase decisions.
    logic        wr_en, wr_new, wr_occ, wr_age, wr_upd;
    logic [IW-1:0] wr_idx;
    logic        ev_set, ev_clr, clr_all;
    logic [7:0]  occ_n, age_n;
    logic        acc, fnd, dval, srst, has_slot, show;
    logic [IW-1:0] slot_idx;
    logic [7:0]  dev, o_occ, o_age, o_conf, o_stat;
    logic [CW-1:0] n_after;

    always_comb begin
        wr_en    = 1'b0;
        wr_new   = 1'b0;
        wr_occ   = 1'b0;
        wr_age   = 1'b0;
        wr_upd   = 1'b0;
        wr_idx   = target;
        ev_set   = 1'b0;
        ev_clr   = 1'b0;
        clr_all  = 1'b0;
        occ_n    = (rd_occ_reg < femt_pkg::SAT_MAX) ? rd_occ_reg + 8'd1 : rd_occ_reg;
        age_n    = (rd_age_reg < rd_lim_reg) ? rd_age_reg + 8'd1 : rd_age_reg;
        acc      = 1'b0;
        fnd      = hit_reg;
        dval     = 1'b0;
        dev      = 8'd0;
        srst     = 1'b0;
        has_slot = 1'b0;
        show     = 1'b0;
        slot_idx = target;
        o_occ    = rd_occ_reg;
        o_age    = rd_age_reg;
        o_conf   = rd_conf_reg;
        o_stat   = rd_stat_reg;
        n_after  = used_reg;
        if (op_reg == femt_pkg::OP_CLR_ALL) begin
            clr_all = 1'b1;
            acc     = 1'b1;
            srst    = 1'b1;
            fnd     = 1'b0;
            n_after = '0;
        end else if (ev_valid && op_reg == femt_pkg::OP_STORE) begin
            if (!cfg_disabled && sok_reg) begin
                if (hit_reg) begin
                    wr_en = 1'b1; wr_occ = 1'b1; wr_upd = 1'b1;
                    acc = 1'b1; has_slot = 1'b1; show = 1'b1;
                    o_occ = occ_n; o_conf = cc_reg; o_stat = st_reg;
                end else if (free_reg || prio_reg < worst_reg) begin
                    wr_en = 1'b1; wr_new = 1'b1; ev_set = 1'b1;
                    acc = 1'b1; has_slot = 1'b1; show = 1'b1;
                    o_occ = 8'd1; o_age = 8'd0; o_conf = 8'd1; o_stat = st_reg;
                    if (free_reg) begin
                        n_after = used_reg + CW'(1);
                    end else begin
                        dval = 1'b1;
                        dev  = slot_event_reg[cand_reg];
                    end
                end
            end else if (hit_reg) begin
                has_slot = 1'b1;
                show     = 1'b1;
            end
        end else if (ev_valid && op_reg == femt_pkg::OP_CLR_ONE) begin
            acc  = 1'b1;
            srst = 1'b1;
            if (hit_reg) begin
                ev_clr   = 1'b1;
                has_slot = 1'b1;
                n_after  = used_reg - CW'(1);
            end
        end else if (ev_valid && op_reg == femt_pkg::OP_AGE) begin
            acc = 1'b1;
            if (hit_reg) begin
                has_slot = 1'b1;
                if (!st_reg[0]) begin
                    if (age_n >= rd_lim_reg) begin
                        ev_clr  = 1'b1;
                        srst    = 1'b1;
                        n_after = used_reg - CW'(1);
                    end else begin
                        wr_en = 1'b1; wr_age = 1'b1;
                        show  = 1'b1;
                        o_age = age_n;
                    end
                end else begin
                    wr_en = 1'b1; wr_age = 1'b1;
                    age_n = 8'd0;
                    show  = 1'b1;
                    o_age = 8'd0;
                end
            end
        end else if (ev_valid && op_reg == femt_pkg::OP_READ) begin
            acc      = 1'b1;
            has_slot = hit_reg;
            show     = hit_reg;
        end else begin
            fnd = 1'b0;
        end
        if (!show) begin
            o_occ = 8'd0; o_age = 8'd0; o_conf = 8'd0; o_stat = 8'd0;
        end
        if (!has_slot) begin
            slot_idx = '0;
        end
    end

    // Memories: one write port for the execute step, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            if (wr_new) begin
                mem_prio[wr_idx] <= prio_reg;
                mem_lim[wr_idx]  <= lim_reg;
                mem_occ[wr_idx]  <= 8'd1;
                mem_age[wr_idx]  <= 8'd0;
                mem_conf[wr_idx] <= 8'd1;
                mem_stat[wr_idx] <= st_reg;
                mem_time[wr_idx] <= ts_reg;
            end
            if (wr_occ) begin
                mem_occ[wr_idx] <= occ_n;
            end
            if (wr_upd) begin
                mem_stat[wr_idx] <= st_reg;
                mem_time[wr_idx] <= ts_reg;
                mem_conf[wr_idx] <= cc_reg;
            end
            if (wr_age) begin
                mem_age[wr_idx] <= age_n;
            end
        end
        rd_prio_reg <= mem_prio[rd_addr];
        rd_lim_reg  <= mem_lim[rd_addr];
        rd_occ_reg  <= mem_occ[rd_addr];
        rd_age_reg  <= mem_age[rd_addr];
        rd_conf_reg <= mem_conf[rd_addr];
        rd_stat_reg <= mem_stat[rd_addr];
        rd_time_reg <= mem_time[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_event_reg[i] <= 8'd0;
            end
        end else if (cmd.exec) begin
            if (clr_all) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    slot_event_reg[i] <= 8'd0;
                end
            end else if (ev_set) begin
                slot_event_reg[wr_idx] <= ev_reg;
            end else if (ev_clr) begin
                slot_event_reg[wr_idx] <= 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg   <= in_op;
            ev_reg   <= in_data[7:0];
            prio_reg <= in_data[15:8];
            lim_reg  <= in_data[23:16];
            st_reg   <= in_data[31:24];
            cc_reg   <= in_data[39:32];
            sok_reg  <= in_data[40];
            ts_reg   <= in_data[72:41];
        end
    end

    // Scan: issue a read at cnt, evaluate the slot read in the previous cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            pv_reg  <= 1'b0;
        end else if (cmd.start) begin
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            used_reg   <= '0;
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
            cand_reg   <= '0;
            worst_reg  <= 8'd0;
            oldest_reg <= femt_pkg::TIME_MAX;
        end else if (cmd.scan) begin
            pv_reg   <= (cnt_reg < CW'(ENTRIES));
            pidx_reg <= cnt_reg[IW-1:0];
            if (cnt_reg < CW'(ENTRIES)) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (pv_reg) begin
                if (pev == 8'd0) begin
                    if (!free_reg) begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= pidx_reg;
                    end
                end else begin
                    used_reg <= used_reg + CW'(1);
                    if (rd_prio_reg > worst_reg ||
                        (rd_prio_reg == worst_reg && rd_time_reg < oldest_reg)) begin
                        worst_reg  <= rd_prio_reg;
                        oldest_reg <= rd_time_reg;
                        cand_reg   <= pidx_reg;
                    end
                end
                if (ev_valid && pev == ev_reg && !hit_reg) begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= pidx_reg;
                end
            end
        end
    end

    logic m_tvalid_reg;
    logic [55:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_tdata_reg <= {4'd0, (n_after >= CW'(ENTRIES)), 4'(n_after), srst,
                            o_stat, o_conf, o_age, o_occ, dev, dval,
                            3'(slot_idx), fnd, acc};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/core/fault_event_memory_table_top.sv */
// Top level of the fault event memory table: joins controller and datapath
// and holds the configuration register. Depends on femt_pkg, femt_ctrl, femt_dp.
//
// Usage: one operation enters per transaction on the s_ channel; the operation
// code travels in s_tuser, its operands in s_tdata. Exactly one result per
// transaction leaves on the m_ channel.
// The slot scan reads one slot per cycle through the single read port of
// the entry store; s_tready is high only while no operation is in progress.
// The result sits in an output register, so the next transaction is taken
// while it waits. If the receiver stalls, a finished operation waits before
// its update until the register is free.
// Reset empties all slots, clears the refuse-store bit and drops m_tvalid.
// cfg_wr_en/cfg_wr_data write the refuse-store bit; write it only when idle.
module fault_event_memory_table_top #(
    parameter int ENTRIES = 8,
    parameter int EVENTS  = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] event_id, [15:8] event_priority, [23:16] age_limit, [31:24] event_status,
    // [39:32] confirm_count, [40] storage_ok, [72:41] timestamp, [79:73] zero
    input  logic [79:0] s_tdata,
    // [2:0] op
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] accepted, [1] found, [4:2] slot, [5] displaced_valid, [13:6] displaced_event,
    // [21:14] occurrence_count, [29:22] aging_count, [37:30] consecutive_failed,
    // [45:38] entry_status, [46] status_reset, [50:47] entry_count, [51] overflow,
    // [55:52] zero
    output logic [55:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    femt_pkg::cmd_t  cmd;
    femt_pkg::stat_t stat;
    logic            disabled_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disabled_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            disabled_reg <= cfg_wr_data;
        end
    end

    femt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    femt_dp #(
        .ENTRIES (ENTRIES),
        .EVENTS  (EVENTS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_op        (s_tuser),
        .in_data      (s_tdata[72:0]),
        .cfg_disabled (disabled_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

/* rtl/core/femt_checker.sv */
// Port-level checker for the fault event memory table, bound to the top level.
// Depends on fault_event_memory_table_top.
module femt_checker #(
    parameter int ENTRIES = 8
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // A held result must not change.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One operation at a time: no new transaction right after one is taken.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // A displacement is only reported for an accepted store.
    a_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> m_tdata[0])
        else $error("displacement without acceptance");

    // Overflow matches a full table.
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[51] |-> m_tdata[50:47] == 4'(ENTRIES))
        else $error("overflow with wrong entry count");

endmodule

bind fault_event_memory_table_top femt_checker #(.ENTRIES(ENTRIES)) u_femt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/tb_fault_event_memory_table_top.sv */
// Testbench for fault_event_memory_table_top: directed and random operations
// checked against a behavioral table model held in a scoreboard class.
// Depends on femt_pkg and the fault_event_memory_table_top RTL.
`timescale 1ns / 100ps

module tb_fault_event_memory_table_top;

    localparam int SLOTS = 8;
    localparam int MAX_EVENT = 255;
    localparam int LATENCY = SLOTS + 4;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [2:0] OP_BAD = 3'd5;
    localparam logic [2:0] OP_LAST_BAD = 3'd7;

    typedef struct packed {
        logic        overflow;
        logic [3:0]  entry_count;
        logic        status_reset;
        logic [7:0]  entry_status;
        logic [7:0]  consecutive_failed;
        logic [7:0]  aging_count;
        logic [7:0]  occurrence_count;
        logic [7:0]  displaced_event;
        logic        displaced_valid;
        logic [2:0]  slot;
        logic        found;
        logic        accepted;
    } fault_result_t;

    typedef struct {
        logic [2:0]  op;
        logic [7:0]  event_id;
        logic [7:0]  priority_num;
        logic [7:0]  age_limit;
        logic [7:0]  status;
        logic [7:0]  confirms;
        logic        storage_ok;
        logic [31:0] stamp;
    } fault_request_t;

    class fault_table_scoreboard;
        logic          store_disabled;
        logic [7:0]    ev_q[SLOTS];
        logic [7:0]    prio_q[SLOTS];
        logic [7:0]    lim_q[SLOTS];
        logic [7:0]    occ_q[SLOTS];
        logic [7:0]    aging_q[SLOTS];
        logic [7:0]    conf_q[SLOTS];
        logic [7:0]    stat_q[SLOTS];
        logic [31:0]   stamp_q[SLOTS];
        fault_result_t pending_results[$];
        int            errors;
        int            checked;

        function new();
            store_disabled = 0;
            errors = 0;
            checked = 0;
            for (int i = 0; i < SLOTS; i++) wipe(i);
        endfunction

        function void wipe(int s);
            ev_q[s] = 0; prio_q[s] = 0; lim_q[s] = 0; occ_q[s] = 0;
            aging_q[s] = 0; conf_q[s] = 0; stat_q[s] = 0; stamp_q[s] = 0;
        endfunction

        function int find_slot(logic [7:0] ev);
            for (int i = 0; i < SLOTS; i++) if (ev_q[i] == ev) return i;
            return -1;
        endfunction

        function int used_slots();
            int n;
            n = 0;
            for (int i = 0; i < SLOTS; i++) if (ev_q[i] != 0) n++;
            return n;
        endfunction

        // Worst entry: largest priority number, ties to the strictly older time.
        function int weakest_slot();
            int          cand;
            logic [7:0]  worst;
            logic [31:0] oldest;
            cand = 0; worst = 0; oldest = 32'hFFFF_FFFF;
            for (int i = 0; i < SLOTS; i++) begin
                if (ev_q[i] == 0) continue;
                if (prio_q[i] > worst || (prio_q[i] == worst && stamp_q[i] < oldest)) begin
                    worst = prio_q[i];
                    oldest = stamp_q[i];
                    cand = i;
                end
            end
            return cand;
        endfunction

        function void note_request(fault_request_t r);
            fault_result_t res;
            logic valid_ev;
            int   hit, sl, s, c, n;
            res = '0;
            sl = -1;
            valid_ev = (r.event_id != 0) && (r.event_id <= MAX_EVENT);
            hit = valid_ev ? find_slot(r.event_id) : -1;
            res.found = (hit >= 0);
            if (r.op == femt_pkg::OP_CLR_ALL) begin
                for (int i = 0; i < SLOTS; i++) wipe(i);
                res.accepted = 1;
                res.status_reset = 1;
                res.found = 0;
            end else if (valid_ev && r.op == femt_pkg::OP_STORE) begin
                sl = hit;
                if (!store_disabled && r.storage_ok) begin
                    if (hit >= 0) begin
                        if (occ_q[hit] != 8'hFF) occ_q[hit]++;
                        stat_q[hit] = r.status;
                        stamp_q[hit] = r.stamp;
                        conf_q[hit] = r.confirms;
                        res.accepted = 1;
                    end else begin
                        s = find_slot(0);
                        if (s < 0) begin
                            c = weakest_slot();
                            if (r.priority_num < prio_q[c]) begin
                                res.displaced_valid = 1;
                                res.displaced_event = ev_q[c];
                                s = c;
                            end
                        end
                        if (s >= 0) begin
                            ev_q[s] = r.event_id; prio_q[s] = r.priority_num;
                            lim_q[s] = r.age_limit; stat_q[s] = r.status;
                            occ_q[s] = 1; aging_q[s] = 0; conf_q[s] = 1;
                            stamp_q[s] = r.stamp;
                            sl = s;
                            res.accepted = 1;
                        end
                    end
                end
            end else if (valid_ev && r.op == femt_pkg::OP_CLR_ONE) begin
                if (hit >= 0) begin
                    wipe(hit);
                    sl = hit;
                end
                res.accepted = 1;
                res.status_reset = 1;
            end else if (valid_ev && r.op == femt_pkg::OP_AGE) begin
                res.accepted = 1;
                sl = hit;
                if (hit >= 0) begin
                    if (!r.status[0]) begin
                        if (aging_q[hit] < lim_q[hit]) aging_q[hit]++;
                        if (aging_q[hit] >= lim_q[hit]) begin
                            wipe(hit);
                            res.status_reset = 1;
                        end
                    end else begin
                        aging_q[hit] = 0;
                    end
                end
            end else if (valid_ev && r.op == femt_pkg::OP_READ) begin
                res.accepted = 1;
                sl = hit;
            end else begin
                res.found = 0;
            end
            n = used_slots();
            res.entry_count = 4'(n);
            res.overflow = (n >= SLOTS);
            if (sl >= 0) begin
                res.slot = 3'(sl);
                if (ev_q[sl] == r.event_id && r.event_id != 0) begin
                    res.occurrence_count = occ_q[sl];
                    res.aging_count = aging_q[sl];
                    res.consecutive_failed = conf_q[sl];
                    res.entry_status = stat_q[sl];
                end
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(fault_result_t got);
            fault_result_t exp;
            if (pending_results.size() == 0) begin
                $error("result arrived with no expectation waiting: %h", got);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            checked++;
            if (got.accepted !== exp.accepted) report("accepted", exp.accepted, got.accepted);
            if (got.found !== exp.found) report("found", exp.found, got.found);
            if (got.slot !== exp.slot) report("slot", exp.slot, got.slot);
            if (got.displaced_valid !== exp.displaced_valid)
                report("displaced_valid", exp.displaced_valid, got.displaced_valid);
            if (got.displaced_event !== exp.displaced_event)
                report("displaced_event", exp.displaced_event, got.displaced_event);
            if (got.occurrence_count !== exp.occurrence_count)
                report("occurrence_count", exp.occurrence_count, got.occurrence_count);
            if (got.aging_count !== exp.aging_count)
                report("aging_count", exp.aging_count, got.aging_count);
            if (got.consecutive_failed !== exp.consecutive_failed)
                report("consecutive_failed", exp.consecutive_failed, got.consecutive_failed);
            if (got.entry_status !== exp.entry_status)
                report("entry_status", exp.entry_status, got.entry_status);
            if (got.status_reset !== exp.status_reset)
                report("status_reset", exp.status_reset, got.status_reset);
            if (got.entry_count !== exp.entry_count)
                report("entry_count", exp.entry_count, got.entry_count);
            if (got.overflow !== exp.overflow) report("overflow", exp.overflow, got.overflow);
        endfunction

        function void report(string field, logic [31:0] exp, logic [31:0] got);
            $error("%s mismatch: expected %0d, got %0d", field, exp, got);
            errors++;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        cfg_wr_en;
    logic        cfg_wr_data;

    fault_table_scoreboard sb;
    int          cycle_count;
    int          sent_items;
    bit          hold_off_req;
    logic [31:0] clock_stamp;

    fault_event_memory_table_top #(.ENTRIES(SLOTS), .EVENTS(MAX_EVENT)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: sample at the edge, then hold ready low for a random gap.
    initial begin
        int gap;
        m_tready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(fault_result_t'(m_tdata[51:0]));
            if (hold_off_req) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                hold_off_req = 0;
            end else begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                  : $urandom_range(0, 2);
                if ($urandom_range(0, 2) == 0) gap = 0;
                if (gap > 0) begin
                    m_tready <= 0;
                    repeat (gap) @(posedge aclk);
                end
                m_tready <= 1;
            end
        end
    end

    task automatic send_request(fault_request_t r);
        s_tvalid <= 1;
        s_tuser <= r.op;
        s_tdata <= {7'd0, r.stamp, r.storage_ok, r.confirms, r.status,
                    r.age_limit, r.priority_num, r.event_id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(r);
        sent_items++;
    endtask

    task automatic idle_sender();
        int gap;
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_disable(logic value);
        cfg_wr_en <= 1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.store_disabled = value;
    endtask

    function automatic fault_request_t make_request(logic [2:0] op, logic [7:0] ev,
                                                    logic [7:0] pr, logic [7:0] st);
        fault_request_t r;
        r.op = op;
        r.event_id = ev;
        r.priority_num = pr;
        r.age_limit = 8'($urandom_range(0, 4));
        r.status = st;
        r.confirms = 8'($urandom);
        r.storage_ok = 1;
        r.stamp = clock_stamp;
        clock_stamp = clock_stamp + 32'($urandom_range(0, 3));
        return r;
    endfunction

    // Mostly stores and ages over a small event pool so the table fills and displaces.
    task automatic random_phase(int count, int pool);
        fault_request_t r;
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            r = make_request(femt_pkg::OP_STORE, 8'($urandom_range(1, pool)),
                             8'($urandom_range(0, 20)), 8'($urandom));
            if (pick < 45) r.op = femt_pkg::OP_STORE;
            else if (pick < 70) r.op = femt_pkg::OP_AGE;
            else if (pick < 80) r.op = femt_pkg::OP_READ;
            else if (pick < 88) r.op = femt_pkg::OP_CLR_ONE;
            else if (pick < 90) r.op = femt_pkg::OP_CLR_ALL;
            else if (pick < 93) r.op = 3'($urandom_range(OP_BAD, OP_LAST_BAD));
            else begin
                r.op = 3'($urandom);
                r.event_id = 8'($urandom);
                r.priority_num = 8'($urandom);
                r.age_limit = 8'($urandom);
            end
            if ($urandom_range(0, 9) == 0) r.storage_ok = 0;
            if ($urandom_range(0, 15) == 0) r.stamp = $urandom;
            if ($urandom_range(0, 15) == 0) r.confirms = 8'hFF;
            send_request(r);
            idle_sender();
        end
    endtask

    initial begin
        fault_request_t r;
        sb = new();
        cycle_count = 0;
        sent_items = 0;
        hold_off_req = 0;
        clock_stamp = 100;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: fill the table, then displacement and its refusal.
        for (int i = 1; i <= SLOTS; i++)
            send_request(make_request(femt_pkg::OP_STORE, 8'(i), 8'(50 + i), 8'd0));
        send_request(make_request(femt_pkg::OP_STORE, 8'd200, 8'd255, 8'd1));
        send_request(make_request(femt_pkg::OP_STORE, 8'd201, 8'd0, 8'hFF));
        send_request(make_request(femt_pkg::OP_STORE, 8'd255, 8'd3, 8'h80));
        send_request(make_request(femt_pkg::OP_STORE, 8'd0, 8'd0, 8'd0));
        send_request(make_request(femt_pkg::OP_READ, 8'd255, 8'd0, 8'd0));
        send_request(make_request(femt_pkg::OP_READ, 8'd77, 8'd0, 8'd0));
        r = make_request(femt_pkg::OP_STORE, 8'd201, 8'd0, 8'h55);
        r.storage_ok = 0;
        send_request(r);
        r = make_request(femt_pkg::OP_AGE, 8'd201, 8'd0, 8'd1);
        send_request(r);
        send_request(make_request(femt_pkg::OP_AGE, 8'd201, 8'd0, 8'd0));
        send_request(make_request(femt_pkg::OP_AGE, 8'd201, 8'd0, 8'd0));
        send_request(make_request(femt_pkg::OP_AGE, 8'd99, 8'd0, 8'd0));
        send_request(make_request(femt_pkg::OP_CLR_ONE, 8'd255, 8'd0, 8'd0));
        send_request(make_request(femt_pkg::OP_CLR_ONE, 8'd99, 8'd0, 8'd0));
        send_request(make_request(OP_BAD, 8'd3, 8'd0, 8'd0));
        send_request(make_request(OP_LAST_BAD, 8'd3, 8'd0, 8'd0));
        send_request(make_request(femt_pkg::OP_CLR_ALL, 8'd0, 8'd0, 8'd0));
        drain();

        // Saturate one occurrence count.
        for (int i = 0; i < 260; i++) begin
            r = make_request(femt_pkg::OP_STORE, 8'd9, 8'd1, 8'($urandom));
            send_request(r);
        end
        drain();

        write_disable(1);
        random_phase(60, 12);
        drain();
        write_disable(0);

        // Receiver holds off while the sender keeps offering.
        hold_off_req = 1;
        random_phase(40, 12);
        random_phase(700, 14);
        drain();
        write_disable(1);
        random_phase(40, 10);
        drain();
        write_disable(0);
        random_phase(230, 40);
        drain();

        $display("Ran %0d operations, %0d results checked, with store refusal on and off.",
                 sent_items, sb.checked);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
